[hdl/bioe_pkg.sv]
// ============================================================================
// bioe_pkg: shared types and constants for the bitmask immediate encoder
// Holds the request, response and internal item formats, the status codes
// and the fixed fields of the ORR (immediate) instruction word.
// ============================================================================
package bioe_pkg;

    // Fixed opcode field, bits 30:23 of the instruction word.
    localparam logic [7:0] ORR_IMM_OPCODE = 8'b0110_0100;
    localparam logic [5:0] SIX_BIT_MASK   = 6'h3f;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SIZE    = 2'd1,
        STATUS_NOT_ENC = 2'd2
    } bioe_status_t;

    typedef struct packed {
        logic [4:0]  dest_reg;
        logic        dest_is_64;
        logic [4:0]  src_reg;
        logic        src_is_64;
        logic [63:0] imm_value;
    } bioe_req_t;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [1:0]  status;
    } bioe_rsp_t;

    // Classified item as written into the queue by the front part.
    typedef struct packed {
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic        sf;
        logic        size_err;
        logic [2:0]  elem_log2;   // element size is 2**elem_log2 bits
        logic [63:0] rep;         // immediate replicated to 64 bits
    } bioe_entry_t;

    // Counts held between the two stages of the back part.
    typedef struct packed {
        logic [4:0] rd;
        logic [4:0] rn;
        logic       sf;
        logic       size_err;
        logic [2:0] elem_log2;
        logic [6:0] ones_total;   // set bits over all 64 bits
        logic [6:0] rise_cnt;     // rising edges over all 64 bits, cyclic
        logic [5:0] rise_pos;     // lowest rising edge position
    } bioe_stage_t;

endpackage

[hdl/bioe_front.sv]
// ============================================================================
// bioe_front: request classification
// Checks the register widths, replicates a 32-bit immediate to 64 bits and
// finds the smallest power-of-two period of the replicated value.
// ============================================================================
module bioe_front (
    input  bioe_pkg::bioe_req_t   req,
    output bioe_pkg::bioe_entry_t entry
);
    import bioe_pkg::*;

    logic [63:0] rep;
    logic [5:0]  periodic;
    logic [2:0]  elem_log2;

    always_comb
    begin
        rep = req.dest_is_64 ? req.imm_value : {req.imm_value[31:0], req.imm_value[31:0]};

        // periodic[j] is set when the value repeats every 2**j bits.
        for (int j = 0; j < 6; j++)
        begin
            periodic[j] = (rep == ((rep >> (1 << j)) | (rep << (64 - (1 << j)))));
        end

        // Periodicity at one size implies it at every larger size, so the
        // element is the smallest size in the unbroken chain from the top.
        elem_log2 = 3'd6;
        for (int j = 5; j >= 0; j--)
        begin
            if (periodic[j] && (elem_log2 == 3'(j + 1)))
            begin
                elem_log2 = 3'(j);
            end
        end

        entry.rd        = req.dest_reg;
        entry.rn        = req.src_reg;
        entry.sf        = req.dest_is_64;
        entry.size_err  = (req.dest_is_64 != req.src_is_64) ||
                          (!req.dest_is_64 && (req.imm_value[63:32] != 32'd0));
        entry.elem_log2 = elem_log2;
        entry.rep       = rep;
    end

endmodule

[hdl/bioe_queue.sv]
// ============================================================================
// bioe_queue: short item queue between the front and back parts
// A small circular buffer with an occupancy count; push and pop may happen
// in the same cycle.
// ============================================================================
module bioe_queue #(
    parameter int DEPTH = bioe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bioe_pkg::bioe_entry_t wr_data,
    output logic                  space,
    input  logic                  pop,
    output logic                  avail,
    output bioe_pkg::bioe_entry_t rd_data
);
    import bioe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bioe_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign space   = (count_reg != CNT_W'(DEPTH));
    assign avail   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/bioe_back.sv]
// ============================================================================
// bioe_back: run check and instruction packing
// Stage one counts set bits and cyclic rising edges of the replicated value
// and locates the first rising edge; stage two validates the run, works out
// N, immr and imms and holds the response for the output channel.
// ============================================================================
module bioe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  avail,
    input  bioe_pkg::bioe_entry_t entry,
    output logic                  pop,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output bioe_pkg::bioe_rsp_t   rsp
);
    import bioe_pkg::*;

    function automatic logic [6:0] count_bits(input logic [63:0] x);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            n = n + 7'(x[i]);
        end
        return n;
    endfunction

    logic        a_valid_reg, a_valid_next;
    logic        b_valid_reg, b_valid_next;
    logic        adv_b;
    bioe_stage_t a_reg, a_next;
    bioe_rsp_t   b_reg, b_next;

    logic [63:0] rise;
    logic [6:0]  elem_size;
    logic [6:0]  ones;
    logic [6:0]  ones_m1;
    logic [6:0]  rot;
    logic [7:0]  imms_hi;
    logic [5:0]  imms;
    logic        encodable;

    assign adv_b     = a_valid_reg && (!b_valid_reg || rsp_ready);
    assign pop       = avail && (!a_valid_reg || adv_b);
    assign rsp_valid = b_valid_reg;
    assign rsp       = b_reg;

    // Stage one: bit counts over the replicated value.
    always_comb
    begin
        // A rising edge sits where a one follows a zero, wrapping at bit 63.
        rise = entry.rep & ~{entry.rep[62:0], entry.rep[63]};

        a_next.rd         = entry.rd;
        a_next.rn         = entry.rn;
        a_next.sf         = entry.sf;
        a_next.size_err   = entry.size_err;
        a_next.elem_log2  = entry.elem_log2;
        a_next.ones_total = count_bits(entry.rep);
        a_next.rise_cnt   = count_bits(rise);
        a_next.rise_pos   = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (rise[i])
            begin
                a_next.rise_pos = 6'(i);
            end
        end
    end

    // Stage two: a single rotated run has exactly one rising edge in each
    // element, which also rules out the all-zeros and all-ones elements.
    always_comb
    begin
        elem_size = 7'd1 << a_reg.elem_log2;
        encodable = (a_reg.rise_cnt == (7'd64 >> a_reg.elem_log2));
        ones      = a_reg.ones_total >> (3'd6 - a_reg.elem_log2);
        ones_m1   = ones - 7'd1;
        rot       = (elem_size - {1'b0, a_reg.rise_pos}) & (elem_size - 7'd1);
        imms_hi   = ~((8'd2 << a_reg.elem_log2) - 8'd1);
        imms      = (imms_hi[5:0] & SIX_BIT_MASK) | ones_m1[5:0];

        if (a_reg.size_err)
        begin
            b_next.instr_word = '0;
            b_next.status     = STATUS_SIZE;
        end
        else if (!encodable)
        begin
            b_next.instr_word = '0;
            b_next.status     = STATUS_NOT_ENC;
        end
        else
        begin
            b_next.instr_word = {a_reg.sf, ORR_IMM_OPCODE, (a_reg.elem_log2 == 3'd6),
                                 rot[5:0], imms, a_reg.rn, a_reg.rd};
            b_next.status     = STATUS_OK;
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (pop)
        begin
            a_valid_next = 1'b1;
        end
        else if (adv_b)
        begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (adv_b)
        begin
            b_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_reg <= a_next;
        end
        if (adv_b)
        begin
            b_reg <= b_next;
        end
    end

endmodule

[hdl/bitmask_immediate_orr_encoder_top.sv]
// ============================================================================
// bitmask_immediate_orr_encoder_top: ORR (immediate) instruction encoder
// Encodes a register pair and a 64-bit logical bitmask immediate into the
// 32-bit ORR (immediate) instruction word, with a status code per item.
// ============================================================================
// The block takes one request item per cycle on the req channel while its
// queue has room and returns exactly one response item per request on the
// rsp channel, in order. Each response carries the instruction word and a
// status: ok, a size error when the two register widths differ or a 32-bit
// request has an immediate wider than 32 bits, or not encodable when the
// repeating element of the immediate is all zeros, all ones or not a single
// rotated run of ones. On any error the instruction word is zero. The
// sustained rate is one item per cycle while rsp_ready stays high; an item
// passes three registers in the block, in order the queue entry, the
// counting stage and the response register, which holds its response.
// The front part classifies the request as it is accepted and writes it into
// a queue of QUEUE_DEPTH items; the back part drains the queue through its
// two stages and stalls on its own when rsp_ready is low, so the request
// side keeps accepting items until the queue is full. No state is kept
// between items.
// ============================================================================
module bitmask_immediate_orr_encoder_top #(
    parameter int QUEUE_DEPTH = bioe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bioe_pkg::bioe_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bioe_pkg::bioe_rsp_t rsp
);
    import bioe_pkg::*;

    bioe_entry_t front_entry;
    bioe_entry_t queue_entry;
    logic        queue_space;
    logic        queue_avail;
    logic        queue_pop;
    logic        push;

    // An item is accepted whenever the queue has room for it.
    assign req_ready = queue_space;
    assign push      = req_valid && queue_space;

    // Front part: width checks and element size search on the incoming item.
    bioe_front u_front (
        .req   (req),
        .entry (front_entry)
    );

    // Queue decoupling acceptance from the back part.
    bioe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_entry),
        .space   (queue_space),
        .pop     (queue_pop),
        .avail   (queue_avail),
        .rd_data (queue_entry)
    );

    // Back part: run check, field extraction and the response register.
    bioe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (queue_avail),
        .entry     (queue_entry),
        .pop       (queue_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
